// ===== src/cct_pkg.sv =====
package cct_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int MAX_EVENTS  = 4;
   localparam int CSR_WIDTH   = 64;
   localparam int CSR_INDEX_W = 3;

   localparam logic [2:0] EV_TOKEN      = 3'd0;
   localparam logic [2:0] EV_WORD_END   = 3'd1;
   localparam logic [2:0] EV_STRING_END = 3'd2;
   localparam logic [2:0] EV_BREAK      = 3'd3;
   localparam logic [2:0] EV_EOT        = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] REG_BREAK_SET   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_WHITE_SET   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_QUOTE_SET   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ESCAPE_BYTE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_CASE_MODE   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_SKIP_LINE   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_SKIP_BLOCK  = 3'd6;

   localparam logic [1:0] CASE_UPPER = 2'd1;
   localparam logic [1:0] CASE_LOWER = 2'd2;

   localparam logic [7:0] CHAR_SLASH   = 8'h2f;
   localparam logic [7:0] CHAR_STAR    = 8'h2a;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

   localparam logic [63:0] BREAK_SET_RESET = 64'd171785004;
   localparam logic [63:0] WHITE_SET_RESET = 64'd854304;
   localparam logic [31:0] QUOTE_SET_RESET = 32'd8743;

   typedef enum logic [1:0] {
      SCAN_WHITE,
      SCAN_WORD,
      SCAN_QUOTED
   } scan_state_type;

   typedef enum logic [1:0] {
      CMT_NONE,
      CMT_LINE,
      CMT_BLOCK
   } comment_mode_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] event_value;
   } event_type;

   typedef struct packed {
      logic [2:0]                 count;
      event_type [MAX_EVENTS-1:0] ev;
   } bundle_type;

   typedef struct packed {
      scan_state_type   scan;
      logic [7:0]       open_quote;
      comment_mode_type comment;
      logic             star_seen;
      logic             slash_pending;
      logic             escape_pending;
   } scan_type;

   typedef struct packed {
      logic [63:0] break_set;
      logic [63:0] white_set;
      logic [31:0] quote_set;
      logic [7:0]  escape_byte;
      logic [1:0]  case_mode;
      logic        skip_line;
      logic        skip_block;
   } cfg_type;

endpackage

// ===== src/cct_req_if.sv =====
interface cct_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] text_byte;

   modport source (output valid, output kind, output text_byte, input ready);
   modport sink (input valid, input kind, input text_byte, output ready);
endinterface

// ===== src/cct_rsp_if.sv =====
interface cct_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [7:0] event_value;
   logic       last;

   modport source (output valid, output event_res, output event_value, output last,
                   input ready);
   modport sink (input valid, input event_res, input event_value, input last,
                 output ready);
endinterface

// ===== src/cct_front.sv =====
module cct_front (
   input  logic                              clock,
   input  logic                              reset,
   cct_req_if.sink                           req,
   input  logic                              csr_we,
   input  logic [cct_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [cct_pkg::CSR_WIDTH-1:0]     csr_data,
   input  logic                              queue_full,
   output logic                              push,
   output cct_pkg::bundle_type               push_bundle
);
   import cct_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   scan_type   scan_ff, scan_in;
   bundle_type bundle;
   logic       fire;

   function automatic void emit(inout bundle_type bd, input logic [2:0] res,
                                input logic [7:0] v);
      if (bd.count < 3'(MAX_EVENTS)) begin
         bd.ev[bd.count[1:0]].event_res   = res;
         bd.ev[bd.count[1:0]].event_value = v;
         bd.count = bd.count + 3'd1;
      end
   endfunction

   function automatic void emit_token(inout bundle_type bd, input logic [7:0] b,
                                      input cfg_type c);
      logic [7:0] v;
      v = b;
      if (c.case_mode == CASE_UPPER && (b inside {[8'h61:8'h7a]})) begin
         v = b - 8'd32;
      end else if (c.case_mode == CASE_LOWER && (b inside {[8'h41:8'h5a]})) begin
         v = b + 8'd32;
      end
      emit(bd, EV_TOKEN, v);
   endfunction

   function automatic logic in_set8(input logic [7:0] b, input logic [63:0] set);
      logic hit;
      logic alive;
      hit   = 1'b0;
      alive = 1'b1;
      for (int i = 0; i < 8; i++) begin
         if (set[8*i +: 8] == 8'd0) begin
            alive = 1'b0;
         end
         if (alive && set[8*i +: 8] == b) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic logic in_set4(input logic [7:0] b, input logic [31:0] set);
      logic hit;
      logic alive;
      hit   = 1'b0;
      alive = 1'b1;
      for (int i = 0; i < 4; i++) begin
         if (set[8*i +: 8] == 8'd0) begin
            alive = 1'b0;
         end
         if (alive && set[8*i +: 8] == b) begin
            hit = 1'b1;
         end
      end
      return hit;
   endfunction

   function automatic void classify(inout scan_type st, inout bundle_type bd,
                                    input logic [7:0] b, input cfg_type c);
      if (in_set8(b, c.break_set)) begin
         if (st.scan == SCAN_QUOTED) begin
            emit_token(bd, b, c);
         end else begin
            if (st.scan == SCAN_WORD) begin
               emit(bd, EV_WORD_END, 8'd0);
            end
            st.scan = SCAN_WHITE;
            emit(bd, EV_BREAK, b);
         end
      end else if (in_set4(b, c.quote_set)) begin
         if (st.scan == SCAN_QUOTED) begin
            if (b == st.open_quote) begin
               emit(bd, EV_STRING_END, b);
               st.scan       = SCAN_WHITE;
               st.open_quote = 8'd0;
            end else begin
               emit_token(bd, b, c);
            end
         end else begin
            if (st.scan == SCAN_WORD) begin
               emit(bd, EV_WORD_END, 8'd0);
            end
            st.scan       = SCAN_QUOTED;
            st.open_quote = b;
         end
      end else if (in_set8(b, c.white_set)) begin
         if (st.scan == SCAN_QUOTED) begin
            emit_token(bd, b, c);
         end else begin
            if (st.scan == SCAN_WORD) begin
               emit(bd, EV_WORD_END, 8'd0);
            end
            st.scan = SCAN_WHITE;
         end
      end else if (c.escape_byte != 8'd0 && b == c.escape_byte) begin
         if (st.scan != SCAN_QUOTED) begin
            st.scan = SCAN_WORD;
         end
         st.escape_pending = 1'b1;
      end else begin
         if (st.scan != SCAN_QUOTED) begin
            st.scan = SCAN_WORD;
         end
         emit_token(bd, b, c);
      end
   endfunction

   function automatic void take_byte(inout scan_type st, inout bundle_type bd,
                                     input logic [7:0] b, input cfg_type c);
      if (st.escape_pending) begin
         st.escape_pending = 1'b0;
         emit_token(bd, b, c);
      end else if (st.scan != SCAN_QUOTED && b == CHAR_SLASH &&
                   (c.skip_line || c.skip_block)) begin
         st.slash_pending = 1'b1;
      end else begin
         classify(st, bd, b, c);
      end
   endfunction

   function automatic void start_comment(inout scan_type st, inout bundle_type bd,
                                         input comment_mode_type mode);
      if (st.scan == SCAN_WORD) begin
         emit(bd, EV_WORD_END, 8'd0);
      end
      st.scan      = SCAN_WHITE;
      st.comment   = mode;
      st.star_seen = 1'b0;
   endfunction

   assign req.ready   = !queue_full;
   assign fire        = req.valid && req.ready;
   assign push        = fire && (bundle.count != 3'd0);
   assign push_bundle = bundle;

   always_comb begin
      scan_type   st;
      bundle_type bd;
      st = scan_ff;
      bd = '0;
      if (req.kind) begin
         if (st.comment == CMT_NONE) begin
            if (st.slash_pending) begin
               st.slash_pending = 1'b0;
               classify(st, bd, CHAR_SLASH, cfg_ff);
            end
            if (st.escape_pending) begin
               st.escape_pending = 1'b0;
               emit_token(bd, cfg_ff.escape_byte, cfg_ff);
            end
            if (st.scan == SCAN_WORD || st.scan == SCAN_QUOTED) begin
               emit(bd, EV_WORD_END, 8'd0);
            end
         end
         emit(bd, EV_EOT, 8'd0);
         st = '{scan: SCAN_WHITE, open_quote: 8'd0, comment: CMT_NONE,
                star_seen: 1'b0, slash_pending: 1'b0, escape_pending: 1'b0};
      end else if (st.comment == CMT_LINE) begin
         if (req.text_byte == CHAR_NEWLINE) begin
            st.comment = CMT_NONE;
         end
      end else if (st.comment == CMT_BLOCK) begin
         if (st.star_seen && req.text_byte == CHAR_SLASH) begin
            st.comment   = CMT_NONE;
            st.star_seen = 1'b0;
         end else begin
            st.star_seen = (req.text_byte == CHAR_STAR);
         end
      end else if (st.slash_pending) begin
         st.slash_pending = 1'b0;
         if (req.text_byte == CHAR_SLASH && cfg_ff.skip_line) begin
            start_comment(st, bd, CMT_LINE);
         end else if (req.text_byte == CHAR_STAR && cfg_ff.skip_block) begin
            start_comment(st, bd, CMT_BLOCK);
         end else begin
            classify(st, bd, CHAR_SLASH, cfg_ff);
            take_byte(st, bd, req.text_byte, cfg_ff);
         end
      end else begin
         take_byte(st, bd, req.text_byte, cfg_ff);
      end
      bundle  = bd;
      scan_in = fire ? st : scan_ff;
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_BREAK_SET:   cfg_in.break_set   = csr_data;
            REG_WHITE_SET:   cfg_in.white_set   = csr_data;
            REG_QUOTE_SET:   cfg_in.quote_set   = csr_data[31:0];
            REG_ESCAPE_BYTE: cfg_in.escape_byte = csr_data[7:0];
            REG_CASE_MODE:   cfg_in.case_mode   = csr_data[1:0];
            REG_SKIP_LINE:   cfg_in.skip_line   = csr_data[0];
            REG_SKIP_BLOCK:  cfg_in.skip_block  = csr_data[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff  <= '{break_set: BREAK_SET_RESET, white_set: WHITE_SET_RESET,
                      quote_set: QUOTE_SET_RESET, escape_byte: 8'd0, case_mode: 2'd0,
                      skip_line: 1'b0, skip_block: 1'b0};
         scan_ff <= '{scan: SCAN_WHITE, open_quote: 8'd0, comment: CMT_NONE,
                      star_seen: 1'b0, slash_pending: 1'b0, escape_pending: 1'b0};
      end else begin
         cfg_ff  <= cfg_in;
         scan_ff <= scan_in;
      end
   end

endmodule

// ===== src/cct_queue.sv =====
module cct_queue #(
   parameter int DEPTH = cct_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cct_pkg::bundle_type push_bundle,
   input  logic                pop,
   output logic                full,
   output logic                empty,
   output cct_pkg::bundle_type head
);
   import cct_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   bundle_type          mem_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       fill_ff, fill_in;
   logic                do_push, do_pop;

   assign full    = (fill_ff == CW'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
   end

endmodule

// ===== src/cct_back.sv =====
module cct_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                queue_empty,
   input  cct_pkg::bundle_type queue_head,
   output logic                pop,
   cct_rsp_if.source           rsp
);
   import cct_pkg::*;

   bundle_type cur_ff, cur_in;
   logic       cur_valid_ff, cur_valid_in;
   logic [1:0] idx_ff, idx_in;
   logic       is_last;
   logic       fire;

   assign is_last         = ({1'b0, idx_ff} == (cur_ff.count - 3'd1));
   assign fire            = rsp.valid && rsp.ready;
   assign rsp.valid       = cur_valid_ff;
   assign rsp.event_res   = cur_ff.ev[idx_ff].event_res;
   assign rsp.event_value = cur_ff.ev[idx_ff].event_value;
   assign rsp.last        = is_last;
   assign pop             = (!cur_valid_ff || (fire && is_last)) && !queue_empty;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (fire) begin
         if (is_last) begin
            cur_valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
      if (pop) begin
         cur_in       = queue_head;
         cur_valid_in = 1'b1;
         idx_in       = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// ===== src/configurable_char_tokenizer.sv =====
// An accepted item's results are written into the queue as one entry, then loaded
// into the output register that drives the result port.
// Throughput: one item per cycle while the queue is not full; the results of an
// item leave one at a time by the single result port; a four-entry queue
// absorbs bursts. Items that only change state give no result and are not queued.
// Reset (synchronous, active high) restores register defaults and scan state and
// empties the queue.
module configurable_char_tokenizer #(
   parameter int QUEUE_DEPTH = cct_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   cct_req_if.sink                         req_stream,
   cct_rsp_if.source                       rsp_stream,
   input  logic                            csr_we,
   input  logic [cct_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [cct_pkg::CSR_WIDTH-1:0]   csr_data
);
   import cct_pkg::*;

   logic       push;
   bundle_type push_bundle;
   logic       pop;
   logic       queue_full;
   logic       queue_empty;
   bundle_type queue_head;

   cct_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_stream),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .queue_full  (queue_full),
      .push        (push),
      .push_bundle (push_bundle)
   );

   cct_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_bundle (push_bundle),
      .pop         (pop),
      .full        (queue_full),
      .empty       (queue_empty),
      .head        (queue_head)
   );

   cct_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_head  (queue_head),
      .pop         (pop),
      .rsp         (rsp_stream)
   );

endmodule

// ===== sim/configurable_char_tokenizer_tb.sv =====
`timescale 1ns / 100ps

module configurable_char_tokenizer_tb;
   import cct_pkg::*;

   localparam logic       KIND_TEXT     = 1'b0;
   localparam logic       KIND_END      = 1'b1;
   localparam logic [1:0] CASE_KEEP     = 2'd0;
   localparam logic [1:0] CASE_THREE    = 2'd3;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         PHASE_ITEMS   = 60;

   typedef struct {
      logic [2:0] res;
      logic [7:0] value;
      logic       last;
   } token_event_type;

   class token_checker;
      cfg_type         cfg;
      scan_type        st;
      token_event_type expected_events[$];
      token_event_type item_events[$];
      int              errors;

      function new();
         cfg.break_set   = BREAK_SET_RESET;
         cfg.white_set   = WHITE_SET_RESET;
         cfg.quote_set   = QUOTE_SET_RESET;
         cfg.escape_byte = 8'h00;
         cfg.case_mode   = CASE_KEEP;
         cfg.skip_line   = 1'b0;
         cfg.skip_block  = 1'b0;
         reset_scan();
         errors = 0;
      endfunction

      function void reset_scan();
         st.scan           = SCAN_WHITE;
         st.open_quote     = 8'h00;
         st.comment        = CMT_NONE;
         st.star_seen      = 1'b0;
         st.slash_pending  = 1'b0;
         st.escape_pending = 1'b0;
      endfunction

      function int pending();
         return expected_events.size();
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         errors++;
      endtask

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_WIDTH-1:0] data);
         case (idx)
            REG_BREAK_SET:   cfg.break_set   = data;
            REG_WHITE_SET:   cfg.white_set   = data;
            REG_QUOTE_SET:   cfg.quote_set   = data[31:0];
            REG_ESCAPE_BYTE: cfg.escape_byte = data[7:0];
            REG_CASE_MODE:   cfg.case_mode   = data[1:0];
            REG_SKIP_LINE:   cfg.skip_line   = data[0];
            REG_SKIP_BLOCK:  cfg.skip_block  = data[0];
            default: ;
         endcase
      endfunction

      function void add(logic [2:0] res, logic [7:0] value);
         token_event_type e;
         if (item_events.size() >= MAX_EVENTS) return;
         e.res   = res;
         e.value = value;
         e.last  = 1'b0;
         item_events = {item_events, e};
      endfunction

      function void add_token(logic [7:0] b);
         if (cfg.case_mode == CASE_UPPER && b >= "a" && b <= "z") b = b - 8'd32;
         else if (cfg.case_mode == CASE_LOWER && b >= "A" && b <= "Z") b = b + 8'd32;
         add(EV_TOKEN, b);
      endfunction

      function bit in_list(logic [7:0] b, logic [63:0] list, int n);
         logic [7:0] m;
         for (int i = 0; i < n; i++) begin
            m = list[8*i +: 8];
            if (m == 8'h00) return 1'b0;
            if (m == b) return 1'b1;
         end
         return 1'b0;
      endfunction

      function void end_word();
         if (st.scan == SCAN_WORD) add(EV_WORD_END, 8'h00);
      endfunction

      function void classify(logic [7:0] b);
         if (in_list(b, cfg.break_set, 8)) begin
            if (st.scan == SCAN_QUOTED) begin
               add_token(b);
            end else begin
               end_word();
               st.scan = SCAN_WHITE;
               add(EV_BREAK, b);
            end
         end else if (in_list(b, {32'h0, cfg.quote_set}, 4)) begin
            if (st.scan == SCAN_QUOTED) begin
               if (b == st.open_quote) begin
                  add(EV_STRING_END, b);
                  st.scan       = SCAN_WHITE;
                  st.open_quote = 8'h00;
               end else begin
                  add_token(b);
               end
            end else begin
               end_word();
               st.scan       = SCAN_QUOTED;
               st.open_quote = b;
            end
         end else if (in_list(b, cfg.white_set, 8)) begin
            if (st.scan == SCAN_QUOTED) begin
               add_token(b);
            end else begin
               end_word();
               st.scan = SCAN_WHITE;
            end
         end else if (cfg.escape_byte != 8'h00 && b == cfg.escape_byte) begin
            if (st.scan != SCAN_QUOTED) st.scan = SCAN_WORD;
            st.escape_pending = 1'b1;
         end else begin
            if (st.scan != SCAN_QUOTED) st.scan = SCAN_WORD;
            add_token(b);
         end
      endfunction

      function void take_byte(logic [7:0] b);
         if (st.escape_pending) begin
            st.escape_pending = 1'b0;
            add_token(b);
         end else if (st.scan != SCAN_QUOTED && b == CHAR_SLASH &&
                      (cfg.skip_line || cfg.skip_block)) begin
            st.slash_pending = 1'b1;
         end else begin
            classify(b);
         end
      endfunction

      function void start_comment(comment_mode_type mode);
         end_word();
         st.scan      = SCAN_WHITE;
         st.comment   = mode;
         st.star_seen = 1'b0;
      endfunction

      function void note_item(logic kind, logic [7:0] b);
         item_events.delete();
         if (kind == KIND_END) begin
            if (st.comment == CMT_NONE) begin
               if (st.slash_pending) begin
                  st.slash_pending = 1'b0;
                  classify(CHAR_SLASH);
               end
               if (st.escape_pending) begin
                  st.escape_pending = 1'b0;
                  add_token(cfg.escape_byte);
               end
               if (st.scan == SCAN_WORD || st.scan == SCAN_QUOTED) add(EV_WORD_END, 8'h00);
            end
            add(EV_EOT, 8'h00);
            reset_scan();
         end else if (st.comment == CMT_LINE) begin
            if (b == CHAR_NEWLINE) st.comment = CMT_NONE;
         end else if (st.comment == CMT_BLOCK) begin
            if (st.star_seen && b == CHAR_SLASH) begin
               st.comment   = CMT_NONE;
               st.star_seen = 1'b0;
            end else begin
               st.star_seen = (b == CHAR_STAR);
            end
         end else if (st.slash_pending) begin
            st.slash_pending = 1'b0;
            if (b == CHAR_SLASH && cfg.skip_line) begin
               start_comment(CMT_LINE);
            end else if (b == CHAR_STAR && cfg.skip_block) begin
               start_comment(CMT_BLOCK);
            end else begin
               classify(CHAR_SLASH);
               take_byte(b);
            end
         end else begin
            take_byte(b);
         end
         if (item_events.size() > 0) item_events[item_events.size()-1].last = 1'b1;
         expected_events = {expected_events, item_events};
      endfunction

      task check_event(logic [2:0] res, logic [7:0] value, logic last);
         token_event_type want;
         if (expected_events.size() == 0) begin
            report($sformatf("unexpected result res=%0d value=%02h last=%0b", res, value, last));
            return;
         end
         want = expected_events.pop_front();
         if (res !== want.res || value !== want.value || last !== want.last)
            report($sformatf("got res=%0d value=%02h last=%0b, want res=%0d value=%02h last=%0b",
                             res, value, last, want.res, want.value, want.last));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_WIDTH-1:0]   csr_data;
   int                     send_idle_pct = 0;
   int                     stall_pct = 0;
   token_checker           tok_check = new();

   cct_req_if req_stream();
   cct_rsp_if rsp_stream();

   configurable_char_tokenizer dut (
      .clock      (clock),
      .reset      (reset),
      .req_stream (req_stream),
      .rsp_stream (rsp_stream),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stream.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_stream.valid && req_stream.ready)
            tok_check.note_item(req_stream.kind, req_stream.text_byte);
         if (rsp_stream.valid && rsp_stream.ready)
            tok_check.check_event(rsp_stream.event_res, rsp_stream.event_value, rsp_stream.last);
      end
   end

   task send_item(input logic kind, input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_stream.valid <= 1'b0;
         @(posedge clock);
      end
      req_stream.valid     <= 1'b1;
      req_stream.kind      <= kind;
      req_stream.text_byte <= b;
      do @(posedge clock); while (!req_stream.ready);
   endtask

   task hold_until_drained();
      req_stream.valid <= 1'b0;
      do @(posedge clock); while (tok_check.pending() != 0);
   endtask

   task settle();
      hold_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task load_config(input cfg_type c);
      logic [CSR_WIDTH-1:0] vals [7];
      vals[REG_BREAK_SET]   = c.break_set;
      vals[REG_WHITE_SET]   = c.white_set;
      vals[REG_QUOTE_SET]   = CSR_WIDTH'(c.quote_set);
      vals[REG_ESCAPE_BYTE] = CSR_WIDTH'(c.escape_byte);
      vals[REG_CASE_MODE]   = CSR_WIDTH'(c.case_mode);
      vals[REG_SKIP_LINE]   = CSR_WIDTH'(c.skip_line);
      vals[REG_SKIP_BLOCK]  = CSR_WIDTH'(c.skip_block);
      for (int i = 0; i < 7; i++) begin
         csr_we    <= 1'b1;
         csr_index <= CSR_INDEX_W'(i);
         csr_data  <= vals[i];
         @(posedge clock);
         tok_check.write_reg(CSR_INDEX_W'(i), vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   function logic [7:0] pick_byte();
      int         sel;
      int         slot;
      logic [7:0] letter;
      sel    = $urandom_range(99);
      slot   = $urandom_range(7);
      letter = 8'("a" + $urandom_range(25));
      if ($urandom_range(1)) letter = letter - 8'd32;
      if (sel < 35) return letter;
      if (sel < 45) return tok_check.cfg.break_set[8*slot +: 8];
      if (sel < 55) return tok_check.cfg.white_set[8*slot +: 8];
      if (sel < 63) return tok_check.cfg.quote_set[8*(slot % 4) +: 8];
      if (sel < 68) return tok_check.cfg.escape_byte;
      if (sel < 76) return CHAR_SLASH;
      if (sel < 81) return CHAR_STAR;
      if (sel < 85) return CHAR_NEWLINE;
      return 8'($urandom_range(255));
   endfunction

   function logic [63:0] random_text_set();
      logic [63:0] s;
      for (int i = 0; i < 8; i++) s[8*i +: 8] = 8'($urandom_range(126, 33));
      return s;
   endfunction

   task run_random(input cfg_type c, input int send_pct, input int stall, input bit pause_midway);
      settle();
      send_idle_pct = send_pct;
      stall_pct     = stall;
      load_config(c);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if (pause_midway && i == PHASE_ITEMS / 2) hold_until_drained();
         if ($urandom_range(29) == 0) send_item(KIND_END, 8'($urandom));
         else send_item(KIND_TEXT, pick_byte());
      end
   endtask

   initial begin
      #400000;
      $display("configurable_char_tokenizer_tb: done, errors");
      $finish;
   end

   initial begin
      cfg_type c;
      cfg_type all_on;
      string   directed;
      reset                <= 1'b1;
      csr_we               <= 1'b0;
      csr_index            <= '0;
      csr_data             <= '0;
      req_stream.valid     <= 1'b0;
      req_stream.kind      <= KIND_TEXT;
      req_stream.text_byte <= 8'h00;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      c                  = tok_check.cfg;
      all_on             = c;
      all_on.escape_byte = "\\";
      all_on.case_mode   = CASE_UPPER;
      all_on.skip_line   = 1'b1;
      all_on.skip_block  = 1'b1;
      load_config(all_on);

      // break and quote inside words, comment openers in words and strings, escapes
      directed = "B,c'd\"'/xe/*f*/\"/*\"\\\"";
      for (int i = 0; i < directed.len(); i++) send_item(KIND_TEXT, directed[i]);
      send_item(KIND_TEXT, 8'h00);
      send_item(KIND_TEXT, 8'hff);
      send_item(KIND_TEXT, "\\");
      send_item(KIND_END, 8'h00);

      run_random(c, 0, 0, 1'b0);

      c           = all_on;
      c.case_mode = CASE_LOWER;
      run_random(c, 48, 0, 1'b1);

      c.break_set   = random_text_set();
      c.white_set   = random_text_set();
      c.quote_set   = 32'(random_text_set());
      c.escape_byte = 8'hff;
      c.case_mode   = CASE_THREE;
      c.skip_line   = 1'b1;
      c.skip_block  = 1'b0;
      run_random(c, 0, 48, 1'b0);

      c.break_set   = ",;=!?.:\n";
      c.white_set   = {8'h20, 8'h09, 8'h0d, 8'h0b, 8'h0c, "_~^"};
      c.quote_set   = "'\"`|";
      c.escape_byte = "\\";
      c.case_mode   = CASE_LOWER;
      c.skip_line   = 1'b0;
      c.skip_block  = 1'b1;
      run_random(c, 28, 28, 1'b0);

      c.break_set   = '0;
      c.white_set   = '1;
      c.quote_set   = '0;
      c.escape_byte = 8'h01;
      c.case_mode   = CASE_UPPER;
      c.skip_line   = 1'b1;
      c.skip_block  = 1'b1;
      run_random(c, 0, 48, 1'b0);

      c.break_set   = {$urandom, $urandom};
      c.white_set   = {$urandom, $urandom};
      c.quote_set   = $urandom;
      c.escape_byte = 8'($urandom);
      c.case_mode   = 2'($urandom);
      c.skip_line   = 1'($urandom);
      c.skip_block  = 1'($urandom);
      run_random(c, 28, 28, 1'b0);

      settle();
      if (tok_check.errors == 0) begin
         $display("configurable_char_tokenizer_tb: done, clean");
      end else begin
         $display("configurable_char_tokenizer_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== configurable_char_tokenizer.f =====
src/cct_pkg.sv
src/cct_req_if.sv
src/cct_rsp_if.sv
src/cct_front.sv
src/cct_queue.sv
src/cct_back.sv
src/configurable_char_tokenizer.sv
sim/configurable_char_tokenizer_tb.sv
